FILE: rtl/core/pcfd_pkg.sv
// Package for the pulse count floor decoder.
// Beat structs, register indexes and message codes; no dependencies.
package pcfd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OTHER_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS   = 2'd2;

    localparam logic [7:0] GAP_TICKS_RESET = 8'd10;

    localparam logic [7:0] FRAME_LIMIT    = 8'd70;
    localparam logic [6:0] ANNOUNCE_LIMIT = 7'd39;
    localparam logic [6:0] CODE_SCROLL_ON  = 7'd52;
    localparam logic [6:0] CODE_SCROLL_OFF = 7'd53;
    localparam logic [5:0] GONG_UP   = 6'd40;
    localparam logic [5:0] GONG_DOWN = 6'd41;
    localparam logic [5:0] GONG_BOTH = 6'd42;
    localparam logic [5:0] GONG_NONE = 6'd0;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic pulse_pin;
        logic scan;
        logic up_pin;
        logic down_pin;
        logic gong_pin;
        logic talk_pin;
        logic hold_pin;
    } pcfd_in_t;

    typedef struct packed {
        logic       floor_valid;
        logic [6:0] floor_code;
        logic       arrow_valid;
        logic       arrow_up;
        logic       arrow_down;
        logic       scroll_on;
        logic       gong_valid;
        logic [5:0] gong_code;
        logic       announce_valid;
        logic [5:0] announce_code;
    } pcfd_out_t;

    // tick after level matching: every flag is active high
    typedef struct packed {
        logic pulse;
        logic scan;
        logic up;
        logic down;
        logic gong;
        logic talk;
        logic hold;
    } pcfd_cls_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pcfd_qstat_t;

endpackage

FILE: rtl/core/pcfd_front.sv
// Front end: matches raw pin levels against the configured active levels.
// Depends on pcfd_pkg.
module pcfd_front import pcfd_pkg::*; (
    input  pcfd_in_t    s_data,
    input  logic        pulse_level,
    input  logic        other_level,
    input  logic        s_valid,
    input  pcfd_qstat_t q_stat,
    output logic        s_ready,
    output logic        push,
    output pcfd_cls_t   push_data
);

    always_comb begin
        push_data.pulse = (s_data.pulse_pin == pulse_level);
        push_data.scan  = s_data.scan;
        push_data.up    = (s_data.up_pin == other_level);
        push_data.down  = (s_data.down_pin == other_level);
        push_data.gong  = (s_data.gong_pin == other_level);
        push_data.talk  = (s_data.talk_pin == other_level);
        push_data.hold  = (s_data.hold_pin == other_level);
    end

    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

endmodule

FILE: rtl/core/pcfd_queue.sv
// Two-entry queue of classified ticks between front and back.
// Depends on pcfd_pkg.
module pcfd_queue import pcfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  pcfd_cls_t   push_data,
    input  logic        pop,
    output pcfd_cls_t   pop_data,
    output pcfd_qstat_t q_stat
);

    pcfd_cls_t         mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

FILE: rtl/core/pcfd_back.sv
// Back end: frame decoder, slow scan handling and the result register.
// Depends on pcfd_pkg.
module pcfd_back import pcfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  gap_ticks,
    input  pcfd_qstat_t q_stat,
    input  pcfd_cls_t   pop_data,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output pcfd_out_t   m_data
);

    logic       pulse_prev_reg, pulse_prev_next;
    logic [7:0] pulse_count_reg, pulse_count_next;
    logic [7:0] gap_count_reg, gap_count_next;
    logic [6:0] frame_code_reg, frame_code_next;
    logic       gong_prev_reg, gong_prev_next;
    logic       talk_prev_reg, talk_prev_next;
    logic       scroll_reg, scroll_next;
    logic [6:0] announced_reg, announced_next;
    logic       m_valid_reg;
    pcfd_out_t  m_data_reg, m_data_next;

    logic [7:0] gap_inc;
    logic       gong_edge;
    logic       talk_edge;

    assign pop = !q_stat.empty && (!m_valid_reg || m_ready);

    always_comb begin
        pulse_prev_next  = pulse_prev_reg;
        pulse_count_next = pulse_count_reg;
        gap_count_next   = gap_count_reg;
        frame_code_next  = frame_code_reg;
        gong_prev_next   = gong_prev_reg;
        talk_prev_next   = talk_prev_reg;
        scroll_next      = scroll_reg;
        announced_next   = announced_reg;
        m_data_next      = '0;
        gap_inc          = gap_count_reg + 8'd1;
        gong_edge        = pop_data.gong && !gong_prev_reg;
        talk_edge        = pop_data.talk && !talk_prev_reg;

        // frame decoder
        if (pop_data.pulse) begin
            gap_count_next  = '0;
            pulse_prev_next = 1'b1;
            if (!pulse_prev_reg) begin
                pulse_count_next = pulse_count_reg + 8'd1;
            end
        end else begin
            pulse_prev_next = 1'b0;
            gap_count_next  = gap_inc;
            if (gap_inc >= gap_ticks) begin
                if (pulse_count_reg != '0 && pulse_count_reg < FRAME_LIMIT
                        && pulse_count_reg != {1'b0, frame_code_reg}) begin
                    frame_code_next         = pulse_count_reg[6:0];
                    m_data_next.floor_valid = 1'b1;
                end
                pulse_count_next = '0;
                gap_count_next   = '0;
            end
        end

        // slow scan, sees the updated frame code
        if (pop_data.scan) begin
            gong_prev_next = pop_data.gong;
            talk_prev_next = pop_data.talk;
            if (!pop_data.hold) begin
                if (frame_code_next == CODE_SCROLL_ON) begin
                    scroll_next = 1'b1;
                end else if (frame_code_next == CODE_SCROLL_OFF) begin
                    scroll_next = 1'b0;
                end
                m_data_next.arrow_valid = 1'b1;
                m_data_next.arrow_up    = pop_data.up;
                m_data_next.arrow_down  = pop_data.down;
                if (gong_edge && (pop_data.up || pop_data.down)) begin
                    m_data_next.gong_valid = 1'b1;
                    case ({pop_data.up, pop_data.down})
                        2'b10:   m_data_next.gong_code = GONG_UP;
                        2'b01:   m_data_next.gong_code = GONG_DOWN;
                        2'b11:   m_data_next.gong_code = GONG_BOTH;
                        default: m_data_next.gong_code = GONG_NONE;
                    endcase
                end
            end
            if (frame_code_next != '0 && frame_code_next < ANNOUNCE_LIMIT
                    && frame_code_next != announced_reg) begin
                announced_next = frame_code_next;
                if (talk_edge) begin
                    m_data_next.announce_valid = 1'b1;
                    m_data_next.announce_code  = frame_code_next[5:0];
                end
            end
        end

        m_data_next.floor_code = frame_code_next;
        m_data_next.scroll_on  = scroll_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_prev_reg  <= 1'b0;
            pulse_count_reg <= '0;
            gap_count_reg   <= '0;
            frame_code_reg  <= '0;
            gong_prev_reg   <= 1'b0;
            talk_prev_reg   <= 1'b0;
            scroll_reg      <= 1'b0;
            announced_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (pop) begin
                pulse_prev_reg  <= pulse_prev_next;
                pulse_count_reg <= pulse_count_next;
                gap_count_reg   <= gap_count_next;
                frame_code_reg  <= frame_code_next;
                gong_prev_reg   <= gong_prev_next;
                talk_prev_reg   <= talk_prev_next;
                scroll_reg      <= scroll_next;
                announced_reg   <= announced_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/pulse_count_floor_decoder.sv
// Top level of the pulse count floor decoder: configuration registers,
// front end, two-entry queue and back end. Depends on pcfd_pkg.
//
//   channel  dir  handshake        payload
//   s_       in   s_valid/s_ready  s_data   (pcfd_in_t, one tick a beat)
//   m_       out  m_valid/m_ready  m_data   (pcfd_out_t, one result a beat)
//   cfg_     in   cfg_we           cfg_index, cfg_wdata
//
// One beat a cycle in each direction while m_ready stays high; a tick taken
// on s_ is written into the queue, then popped into the result register
// that drives m_. The back end's state update on each pop sets the rate.
// aresetn is synchronous; it clears the queue and decoder state and sets the config to its reset values.
// A stalled m_ side fills the queue and then drops s_ready.
module pulse_count_floor_decoder import pcfd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pcfd_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pcfd_out_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic        pulse_level_reg;
    logic        other_level_reg;
    logic [7:0]  gap_ticks_reg;

    logic        push;
    logic        pop;
    pcfd_cls_t   push_data;
    pcfd_cls_t   pop_data;
    pcfd_qstat_t q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_level_reg <= 1'b1;
            other_level_reg <= 1'b1;
            gap_ticks_reg   <= GAP_TICKS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PULSE_LEVEL: pulse_level_reg <= cfg_wdata[0];
                CFG_OTHER_LEVEL: other_level_reg <= cfg_wdata[0];
                CFG_GAP_TICKS:   gap_ticks_reg   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    pcfd_front u_front (
        .s_data      (s_data),
        .pulse_level (pulse_level_reg),
        .other_level (other_level_reg),
        .s_valid     (s_valid),
        .q_stat      (q_stat),
        .s_ready     (s_ready),
        .push        (push),
        .push_data   (push_data)
    );

    pcfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    pcfd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gap_ticks (gap_ticks_reg),
        .q_stat    (q_stat),
        .pop_data  (pop_data),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !s_ready)
        else $error("input taken while queue full");

    a_gong_needs_arrow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.gong_valid) |-> m_data.arrow_valid)
        else $error("gong without arrow report");

    a_announce_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.announce_valid) |->
            ({1'b0, m_data.announce_code} == m_data.floor_code
             && m_data.announce_code != '0)
        )
        else $error("announcement does not match floor code");

    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_valid)
        else $error("popped tick gave no result");

endmodule
